### hdl/qpw_pkg.sv
// Package for the quad projective weights unit: payload structs and status codes.
// No dependencies.
package qpw_pkg;

	localparam int COORD_W = 16;
	localparam int WEIGHT_W = 24;
	localparam int PROD_W = 34;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_S_RANGE  = 2'd2,
		ST_T_RANGE  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] corner0_x;
		logic signed [COORD_W-1:0] corner0_y;
		logic signed [COORD_W-1:0] corner1_x;
		logic signed [COORD_W-1:0] corner1_y;
		logic signed [COORD_W-1:0] corner2_x;
		logic signed [COORD_W-1:0] corner2_y;
		logic signed [COORD_W-1:0] corner3_x;
		logic signed [COORD_W-1:0] corner3_y;
	} in_word_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight0;
		logic [WEIGHT_W-1:0] weight1;
		logic [WEIGHT_W-1:0] weight2;
		logic [WEIGHT_W-1:0] weight3;
		status_t             status;
	} out_word_t;

endpackage

### hdl/qpw_divider.sv
// Pipelined restoring divider: floor(num * 2^FRAC / den), saturated to WEIGHT_W bits.
// Uses qpw_pkg for widths. One quotient bit per stage, stall by common enable.
module qpw_divider #(
	parameter int NUM_W = 34,
	parameter int FRAC = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [NUM_W-1:0]               num,
	input  logic [NUM_W-1:0]               den,
	output logic [qpw_pkg::WEIGHT_W-1:0]   quot
);
	// quotient bits needed: value < 2^(NUM_W+FRAC); track saturation beyond WEIGHT_W
	localparam int QB = NUM_W + FRAC;
	localparam int WW = qpw_pkg::WEIGHT_W;

	logic [NUM_W-1:0] rem_s [QB+1];
	logic [NUM_W-1:0] den_s [QB+1];
	logic [NUM_W-1:0] num_s [QB+1];
	logic [WW-1:0]    q_s   [QB+1];
	logic             sat_s [QB+1];

	assign rem_s[0] = '0;
	assign den_s[0] = den;
	assign num_s[0] = num;
	assign q_s[0] = '0;
	assign sat_s[0] = 1'b0;

	for (genvar i = 0; i < QB; i++) begin : g_stage
		// numerator bits enter MSB first, then FRAC zero bits for the fraction
		localparam int NB_IDX = (i < NUM_W) ? NUM_W - 1 - i : 0;
		logic [NUM_W:0] trial;
		logic           nb;
		logic           bit_q;
		always_comb begin
			nb = (i < NUM_W) ? num_s[i][NB_IDX] : 1'b0;
			trial = {rem_s[i], nb};
			bit_q = trial >= {1'b0, den_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= bit_q ? NUM_W'(trial - {1'b0, den_s[i]}) : trial[NUM_W-1:0];
				den_s[i+1] <= den_s[i];
				num_s[i+1] <= num_s[i];
				q_s[i+1]   <= {q_s[i][WW-2:0], bit_q};
				sat_s[i+1] <= sat_s[i] | q_s[i][WW-1];
			end
		end
	end

	assign quot = sat_s[QB] ? {WW{1'b1}} : q_s[QB];

endmodule

### hdl/quad_projective_weights_unit.sv
// Quad projective weights unit: diagonal intersection and four perspective weights.
// One word per cycle while the output is not stalled.
// The divider pipeline (one quotient bit per stage) sets the latency.
// Stalls freeze the whole pipe through a global enable; no word is lost.
// arst_n clears all valid bits; payload registers are not reset.
module quad_projective_weights_unit #(
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qpw_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output qpw_pkg::out_word_t out_data
);
	localparam int PW = qpw_pkg::PROD_W;
	localparam int DIVL = PW + WEIGHT_FRAC_BITS;
	localparam int LAT = 4 + DIVL;

	logic en;
	logic [LAT-1:0] vld_q;
	assign out_valid = vld_q[LAT-1];
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// stage 1: differences
	logic signed [16:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= 17'(in_data.corner2_x) - 17'(in_data.corner0_x);
			ay_s1 <= 17'(in_data.corner2_y) - 17'(in_data.corner0_y);
			bx_s1 <= 17'(in_data.corner3_x) - 17'(in_data.corner1_x);
			by_s1 <= 17'(in_data.corner3_y) - 17'(in_data.corner1_y);
			cx_s1 <= 17'(in_data.corner0_x) - 17'(in_data.corner1_x);
			cy_s1 <= 17'(in_data.corner0_y) - 17'(in_data.corner1_y);
		end
	end

	// stage 2: products
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2 <= PW'(ax_s1 * by_s1);
			p1_s2 <= PW'(ay_s1 * bx_s1);
			p2_s2 <= PW'(ax_s1 * cy_s1);
			p3_s2 <= PW'(ay_s1 * cx_s1);
			p4_s2 <= PW'(bx_s1 * cy_s1);
			p5_s2 <= PW'(by_s1 * cx_s1);
		end
	end

	// stage 3: determinant and numerators, sign normalized
	logic signed [PW:0] d_c, sn_c, tn_c;
	logic signed [PW:0] d_s3, sn_s3, tn_s3;
	always_comb begin
		d_c  = (PW+1)'(p0_s2) - (PW+1)'(p1_s2);
		sn_c = (PW+1)'(p2_s2) - (PW+1)'(p3_s2);
		tn_c = (PW+1)'(p4_s2) - (PW+1)'(p5_s2);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3  <= d_c[PW]  ? -d_c  : d_c;
			sn_s3 <= d_c[PW]  ? -sn_c : sn_c;
			tn_s3 <= d_c[PW]  ? -tn_c : tn_c;
		end
	end

	// stage 4: range checks and divider operands
	qpw_pkg::status_t st_s4;
	logic [PW-1:0] num_s4, den0_s4, den1_s4, den2_s4, den3_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= PW'(d_s3);
			den0_s4 <= PW'(d_s3 - tn_s3);
			den1_s4 <= PW'(d_s3 - sn_s3);
			den2_s4 <= PW'(tn_s3);
			den3_s4 <= PW'(sn_s3);
			if (d_s3 == '0)
				st_s4 <= qpw_pkg::ST_PARALLEL;
			else if (!(sn_s3 > 0 && sn_s3 < d_s3))
				st_s4 <= qpw_pkg::ST_S_RANGE;
			else if (!(tn_s3 > 0 && tn_s3 < d_s3))
				st_s4 <= qpw_pkg::ST_T_RANGE;
			else
				st_s4 <= qpw_pkg::ST_OK;
		end
	end

	// zero denominators only occur with a bad status; the divider output is then masked
	logic [qpw_pkg::WEIGHT_W-1:0] w0, w1, w2, w3;
	qpw_divider #(.NUM_W(PW), .FRAC(WEIGHT_FRAC_BITS)) u_div0 (
		.clk(clk), .en(en), .num(num_s4), .den(den0_s4), .quot(w0));
	qpw_divider #(.NUM_W(PW), .FRAC(WEIGHT_FRAC_BITS)) u_div1 (
		.clk(clk), .en(en), .num(num_s4), .den(den1_s4), .quot(w1));
	qpw_divider #(.NUM_W(PW), .FRAC(WEIGHT_FRAC_BITS)) u_div2 (
		.clk(clk), .en(en), .num(num_s4), .den(den2_s4), .quot(w2));
	qpw_divider #(.NUM_W(PW), .FRAC(WEIGHT_FRAC_BITS)) u_div3 (
		.clk(clk), .en(en), .num(num_s4), .den(den3_s4), .quot(w3));

	// carry status alongside the divider stages
	qpw_pkg::status_t st_q [DIVL];
	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= st_s4;
			for (int i = 1; i < DIVL; i++) st_q[i] <= st_q[i-1];
		end
	end

	always_comb begin
		out_data.status = st_q[DIVL-1];
		if (st_q[DIVL-1] == qpw_pkg::ST_OK) begin
			out_data.weight0 = w0;
			out_data.weight1 = w1;
			out_data.weight2 = w2;
			out_data.weight3 = w3;
		end else begin
			out_data.weight0 = '0;
			out_data.weight1 = '0;
			out_data.weight2 = '0;
			out_data.weight3 = '0;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != qpw_pkg::ST_OK |->
		out_data.weight0 == '0 && out_data.weight3 == '0)
		else $error("nonzero weight with bad status");

endmodule

### sim/testbench.sv
// Testbench for quad_projective_weights_unit: drives random and corner-case quads and
// checks every output word against a built-in predictor of the diagonal-intersection weights.
// Depends on qpw_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int WFRAC = 16;
	localparam int LATENCY = 4 + 34 + WFRAC;
	localparam int STALL_LIMIT = 20000;
	localparam logic [23:0] WMAX = 24'hFFFFFF;

	// floor(num * 2^WFRAC / den), saturated at the weight maximum
	function automatic logic [23:0] weight_ratio(longint num, longint den);
		longint q;
		longint r;
		q = num / den;
		r = num % den;
		for (int i = 0; i < WFRAC; i++) begin
			if (q > longint'(WMAX))
				return WMAX;
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return (q > longint'(WMAX)) ? WMAX : q[23:0];
	endfunction

	function automatic qpw_pkg::out_word_t quad_weights(qpw_pkg::in_word_t w);
		qpw_pkg::out_word_t res;
		longint ax, ay, bx, by, cx, cy, d, sn, tn;
		ax = longint'(w.corner2_x) - longint'(w.corner0_x);
		ay = longint'(w.corner2_y) - longint'(w.corner0_y);
		bx = longint'(w.corner3_x) - longint'(w.corner1_x);
		by = longint'(w.corner3_y) - longint'(w.corner1_y);
		cx = longint'(w.corner0_x) - longint'(w.corner1_x);
		cy = longint'(w.corner0_y) - longint'(w.corner1_y);
		d = ax * by - ay * bx;
		sn = ax * cy - ay * cx;
		tn = bx * cy - by * cx;
		res = '0;
		res.status = qpw_pkg::ST_OK;
		if (d == 0) begin
			res.status = qpw_pkg::ST_PARALLEL;
		end else begin
			if (d < 0) begin
				d = -d;
				sn = -sn;
				tn = -tn;
			end
			if (!(sn > 0 && sn < d)) begin
				res.status = qpw_pkg::ST_S_RANGE;
			end else if (!(tn > 0 && tn < d)) begin
				res.status = qpw_pkg::ST_T_RANGE;
			end else begin
				res.weight0 = weight_ratio(d, d - tn);
				res.weight1 = weight_ratio(d, d - sn);
				res.weight2 = weight_ratio(d, tn);
				res.weight3 = weight_ratio(d, sn);
			end
		end
		return res;
	endfunction

	class weight_scoreboard;
		qpw_pkg::out_word_t pending[$];
		int errors;

		function void note_quad(qpw_pkg::in_word_t w);
			pending.push_back(quad_weights(w));
		endfunction

		function void check_word(qpw_pkg::out_word_t got);
			qpw_pkg::out_word_t exp;
			if (pending.size() == 0) begin
				$error("unexpected output word %h", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.weight0 !== exp.weight0) begin
				$error("weight0 expected %0d actual %0d", exp.weight0, got.weight0);
				errors++;
			end
			if (got.weight1 !== exp.weight1) begin
				$error("weight1 expected %0d actual %0d", exp.weight1, got.weight1);
				errors++;
			end
			if (got.weight2 !== exp.weight2) begin
				$error("weight2 expected %0d actual %0d", exp.weight2, got.weight2);
				errors++;
			end
			if (got.weight3 !== exp.weight3) begin
				$error("weight3 expected %0d actual %0d", exp.weight3, got.weight3);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status expected %0d actual %0d", exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	qpw_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	qpw_pkg::out_word_t out_data;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;
	weight_scoreboard board = new();

	quad_projective_weights_unit #(.WEIGHT_FRAC_BITS(WFRAC)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sample handshakes and check results at each edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_quad(in_data);
			if (out_valid && out_ready)
				board.check_word(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: stall at random by the current phase rate.
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Drop valid only while idling, so back-to-back words keep it high.
	task automatic send_quad(qpw_pkg::in_word_t w);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(8192)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	// A convex quad around a random center gives both parameters inside (0,1).
	function automatic qpw_pkg::in_word_t convex_quad();
		qpw_pkg::in_word_t w;
		int cx, cy, r0, r1, r2, r3;
		cx = int'($urandom_range(16384)) - 8192;
		cy = int'($urandom_range(16384)) - 8192;
		r0 = $urandom_range(20000, 1);
		r1 = $urandom_range(20000, 1);
		r2 = $urandom_range(20000, 1);
		r3 = $urandom_range(20000, 1);
		if ($urandom_range(3) == 0) begin
			r0 = $urandom_range(3, 1);
			r3 = $urandom_range(3, 1);
		end
		w.corner0_x = 16'(cx - r0); w.corner0_y = 16'(cy - r0 / 2);
		w.corner1_x = 16'(cx + r1 / 3); w.corner1_y = 16'(cy - r1);
		w.corner2_x = 16'(cx + r2); w.corner2_y = 16'(cy + r2 / 2);
		w.corner3_x = 16'(cx - r3 / 3); w.corner3_y = 16'(cy + r3);
		return w;
	endfunction

	function automatic qpw_pkg::in_word_t noise_quad();
		qpw_pkg::in_word_t w;
		w.corner0_x = pick_coord(); w.corner0_y = pick_coord();
		w.corner1_x = pick_coord(); w.corner1_y = pick_coord();
		w.corner2_x = pick_coord(); w.corner2_y = pick_coord();
		w.corner3_x = pick_coord(); w.corner3_y = pick_coord();
		return w;
	endfunction

	function automatic qpw_pkg::in_word_t make_quad(int x0, int y0, int x1, int y1,
			int x2, int y2, int x3, int y3);
		qpw_pkg::in_word_t w;
		w.corner0_x = 16'(x0); w.corner0_y = 16'(y0);
		w.corner1_x = 16'(x1); w.corner1_y = 16'(y1);
		w.corner2_x = 16'(x2); w.corner2_y = 16'(y2);
		w.corner3_x = 16'(x3); w.corner3_y = 16'(y3);
		return w;
	endfunction

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++)
			send_quad(($urandom_range(9) < 7) ? convex_quad() : noise_quad());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unit square, skewed quads, extremes, each failing status.
		send_quad(make_quad(-16384, -16384, 16384, -16384, 16384, 16384, -16384, 16384));
		send_quad(make_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
		send_quad(make_quad(-32768, 0, 0, -32768, 32767, 0, 0, 32767));
		send_quad(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
		send_quad(make_quad(0, 0, 10, 0, 20, 0, 30, 0));
		send_quad(make_quad(-100, -100, 100, -100, -50, -50, -100, 100));
		send_quad(make_quad(-1000, -1000, -900, -1000, 1000, 1000, 2000, -500));
		send_quad(make_quad(-1000, 0, 0, -1000, 1000, 0, 0, -999));
		send_quad(make_quad(-20000, -1, 1, -20000, 1, 1, -1, 20000));
		send_quad(make_quad(-1, -1, 32767, -32768, 32767, 32767, -32768, 32767));
		send_quad(make_quad(-32768, -32768, 1, -1, 32767, 32767, -1, 1));
		send_quad(make_quad(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768));
		send_quad(make_quad(0, 0, 32767, 0, 32767, 32767, 0, 32767));
		send_quad(make_quad(-16384, -16384, 16384, -16384, -16384, -16384, -16384, 16384));

		run_phase(0, 0, 250);
		run_phase(79, 0, 200);
		run_phase(0, 79, 200);
		run_phase(31, 31, 250);

		send_idle_pct = 0;
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
